@@ hdl/imu_sd_pkg.sv @@
// Shared types and constants for the IMU step and shake detector.
package imu_sd_pkg;

	localparam int NUM_REGS  = 8;
	localparam int REG_IDX_W = 3;
	localparam int CFG_W     = 16;

	typedef enum logic [REG_IDX_W-1:0] {
		REG_STEP_PEAK     = 3'd0,
		REG_STEP_VALLEY   = 3'd1,
		REG_MIN_STEP_GAP  = 3'd2,
		REG_VALLEY_TMO    = 3'd3,
		REG_SHAKE_ACCEL   = 3'd4,
		REG_SHAKE_GYRO    = 3'd5,
		REG_SHAKE_GAP     = 3'd6,
		REG_SHAKE_WINDOW  = 3'd7
	} reg_idx_t;

	localparam logic [CFG_W-1:0] RST_STEP_PEAK    = 16'd9421;
	localparam logic [CFG_W-1:0] RST_STEP_VALLEY  = 16'd7782;
	localparam logic [CFG_W-1:0] RST_MIN_STEP_GAP = 16'd200;
	localparam logic [CFG_W-1:0] RST_VALLEY_TMO   = 16'd500;
	localparam logic [CFG_W-1:0] RST_SHAKE_ACCEL  = 16'd14746;
	localparam logic [CFG_W-1:0] RST_SHAKE_GYRO   = 16'd8515;
	localparam logic [CFG_W-1:0] RST_SHAKE_GAP    = 16'd120;
	localparam logic [CFG_W-1:0] RST_SHAKE_WINDOW = 16'd1000;

	// 410 LSB squared, about 0.05 g
	localparam logic [31:0] QUIET_SQ = 32'd168100;

	localparam logic FUNC_SAMPLE = 1'b0;
	localparam logic FUNC_CLEAR  = 1'b1;

	localparam int QDEPTH = 4;
	localparam int QPTR_W = 2;
	localparam int QCNT_W = 3;

	localparam logic [1:0] SHAKE_EV_MAX  = 2'd3;
	localparam logic [1:0] SHAKE_EV_FIRE = 2'd2;

	typedef struct packed {
		logic               func;
		logic signed [15:0] accel_x;
		logic signed [15:0] accel_y;
		logic signed [15:0] accel_z;
		logic signed [15:0] gyro_x;
		logic signed [15:0] gyro_y;
		logic signed [15:0] gyro_z;
		logic [31:0]        time_ms;
	} sample_t;

	typedef struct packed {
		logic        step_seen;
		logic        shake_seen;
		logic [23:0] step_total;
	} result_t;

	typedef struct packed {
		logic [CFG_W-1:0] step_peak_level;
		logic [CFG_W-1:0] step_valley_level;
		logic [CFG_W-1:0] min_step_gap_ms;
		logic [CFG_W-1:0] valley_timeout_ms;
		logic [CFG_W-1:0] shake_accel_level;
		logic [CFG_W-1:0] shake_gyro_level;
		logic [CFG_W-1:0] shake_gap_ms;
		logic [CFG_W-1:0] shake_window_ms;
	} cfg_t;

	// classified sample handed from front to back
	typedef struct packed {
		logic        clear;
		logic        quiet;
		logic        shake_hit;
		logic        above_peak;
		logic        below_valley;
		logic [31:0] time_ms;
	} class_t;

endpackage

@@ hdl/imu_sd_if.sv @@
// Valid/ready channel carrying one payload item per transfer.
interface imu_sd_if #(
	parameter type payload_t = logic
) ();
	logic     valid;
	logic     ready;
	payload_t payload;

	modport source (output valid, output payload, input ready);
	modport sink   (input valid, input payload, output ready);
endinterface

@@ hdl/imu_sd_front.sv @@
// Front end: accepts samples, squares the axes and classifies against the levels.
module imu_sd_front (
	input  logic                 clk,
	input  logic                 arst_n,
	input  imu_sd_pkg::cfg_t     cfg,
	imu_sd_if.sink               sample,
	input  logic                 q_pop,
	output logic                 q_push,
	output imu_sd_pkg::class_t   q_data
);
	import imu_sd_pkg::*;

	logic [QCNT_W-1:0] credit_q;
	logic              accept;

	logic               v_s1;
	logic               func_s1;
	logic [31:0]        time_s1;
	logic [30:0]        sq_ax_s1, sq_ay_s1, sq_az_s1;
	logic [30:0]        sq_gx_s1, sq_gy_s1, sq_gz_s1;

	logic signed [31:0] p_ax, p_ay, p_az, p_gx, p_gy, p_gz;
	logic [31:0]        thr_peak_q, thr_valley_q, thr_sacc_q, thr_sgyr_q;
	logic [31:0]        acc2, gyr2;

	// credits cover the sample stage plus every queue entry
	assign sample.ready = credit_q < QCNT_W'(QDEPTH);
	assign accept       = sample.valid & sample.ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			credit_q <= '0;
		end else if (accept && !q_pop) begin
			credit_q <= credit_q + QCNT_W'(1);
		end else if (!accept && q_pop) begin
			credit_q <= credit_q - QCNT_W'(1);
		end
	end

	assign p_ax = sample.payload.accel_x * sample.payload.accel_x;
	assign p_ay = sample.payload.accel_y * sample.payload.accel_y;
	assign p_az = sample.payload.accel_z * sample.payload.accel_z;
	assign p_gx = sample.payload.gyro_x * sample.payload.gyro_x;
	assign p_gy = sample.payload.gyro_y * sample.payload.gyro_y;
	assign p_gz = sample.payload.gyro_z * sample.payload.gyro_z;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
		end else begin
			v_s1 <= accept;
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			func_s1  <= sample.payload.func;
			time_s1  <= sample.payload.time_ms;
			sq_ax_s1 <= p_ax[30:0];
			sq_ay_s1 <= p_ay[30:0];
			sq_az_s1 <= p_az[30:0];
			sq_gx_s1 <= p_gx[30:0];
			sq_gy_s1 <= p_gy[30:0];
			sq_gz_s1 <= p_gz[30:0];
		end
	end

	// squared levels are registered copies of the level registers, so they follow them in the next cycle
	always_ff @(posedge clk) begin
		thr_peak_q   <= 32'(cfg.step_peak_level) * 32'(cfg.step_peak_level);
		thr_valley_q <= 32'(cfg.step_valley_level) * 32'(cfg.step_valley_level);
		thr_sacc_q   <= 32'(cfg.shake_accel_level) * 32'(cfg.shake_accel_level);
		thr_sgyr_q   <= 32'(cfg.shake_gyro_level) * 32'(cfg.shake_gyro_level);
	end

	assign acc2 = 32'(sq_ax_s1) + 32'(sq_ay_s1) + 32'(sq_az_s1);
	assign gyr2 = 32'(sq_gx_s1) + 32'(sq_gy_s1) + 32'(sq_gz_s1);

	assign q_push              = v_s1;
	assign q_data.clear        = (func_s1 == FUNC_CLEAR);
	assign q_data.quiet        = acc2 < QUIET_SQ;
	assign q_data.shake_hit    = (acc2 > thr_sacc_q) && (gyr2 > thr_sgyr_q);
	assign q_data.above_peak   = acc2 > thr_peak_q;
	assign q_data.below_valley = acc2 < thr_valley_q;
	assign q_data.time_ms      = time_s1;

endmodule

@@ hdl/imu_sd_fifo.sv @@
// Short queue of classified samples between front and back.
module imu_sd_fifo (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               push,
	input  imu_sd_pkg::class_t push_data,
	input  logic               pop,
	output logic               nempty,
	output logic               full,
	output imu_sd_pkg::class_t head
);
	import imu_sd_pkg::*;

	class_t            entry_q [QDEPTH];
	logic [QPTR_W-1:0] wr_ptr_q, rd_ptr_q;
	logic [QCNT_W-1:0] count_q;

	assign nempty = count_q != '0;
	assign full   = count_q == QCNT_W'(QDEPTH);
	assign head   = entry_q[rd_ptr_q];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= wr_ptr_q + QPTR_W'(1);
			end
			if (pop) begin
				rd_ptr_q <= rd_ptr_q + QPTR_W'(1);
			end
			if (push && !pop) begin
				count_q <= count_q + QCNT_W'(1);
			end else if (!push && pop) begin
				count_q <= count_q - QCNT_W'(1);
			end
		end
	end

	always_ff @(posedge clk) begin
		if (push) begin
			entry_q[wr_ptr_q] <= push_data;
		end
	end

endmodule

@@ hdl/imu_sd_back.sv @@
// Back end: shake and step state machines, step counter and result register.
module imu_sd_back #(
	parameter int COUNT_BITS = 24
) (
	input  logic               clk,
	input  logic               arst_n,
	input  imu_sd_pkg::cfg_t   cfg,
	input  logic               q_nempty,
	input  imu_sd_pkg::class_t q_head,
	output logic               q_pop,
	imu_sd_if.source           result
);
	import imu_sd_pkg::*;

	logic                  awaiting_valley_q;
	logic [31:0]           last_step_time_q, peak_time_q, last_shake_time_q;
	logic [1:0]            shake_events_q;
	logic [COUNT_BITS-1:0] step_cnt_q;

	logic                  awaiting_n;
	logic [31:0]           last_step_n, peak_n, last_shake_n;
	logic [1:0]            events_n;
	logic [COUNT_BITS-1:0] cnt_n;
	logic                  step, shake;
	logic [31:0]           d_shake, d_step, d_peak, cnt_ext;
	logic                  shake_counted;

	logic    out_valid_q;
	result_t out_q;

	assign q_pop          = q_nempty && (!out_valid_q || result.ready);
	assign result.valid   = out_valid_q;
	assign result.payload = out_q;

	assign d_shake = q_head.time_ms - last_shake_time_q;
	assign d_step  = q_head.time_ms - last_step_time_q;
	assign d_peak  = q_head.time_ms - peak_time_q;

	always_comb begin
		awaiting_n    = awaiting_valley_q;
		last_step_n   = last_step_time_q;
		peak_n        = peak_time_q;
		last_shake_n  = last_shake_time_q;
		events_n      = shake_events_q;
		cnt_n         = step_cnt_q;
		step          = 1'b0;
		shake         = 1'b0;
		shake_counted = 1'b0;
		if (q_head.clear) begin
			cnt_n = '0;
		end else if (!q_head.quiet) begin
			if (q_head.shake_hit && (d_shake > 32'(cfg.shake_gap_ms))) begin
				shake_counted = 1'b1;
				last_shake_n  = q_head.time_ms;
				if (shake_events_q != SHAKE_EV_MAX) begin
					events_n = shake_events_q + 2'd1;
				end
			end
			if (events_n >= SHAKE_EV_FIRE) begin
				shake    = 1'b1;
				events_n = '0;
			end
			// a freshly counted event leaves zero idle time
			if (!shake_counted && (d_shake > 32'(cfg.shake_window_ms))) begin
				events_n = '0;
			end

			if (!awaiting_valley_q) begin
				if (q_head.above_peak && (d_step > 32'(cfg.min_step_gap_ms))) begin
					awaiting_n = 1'b1;
					peak_n     = q_head.time_ms;
				end
			end else if (q_head.below_valley) begin
				if (!(&step_cnt_q)) begin
					cnt_n = step_cnt_q + COUNT_BITS'(1);
				end
				last_step_n = q_head.time_ms;
				awaiting_n  = 1'b0;
				step        = 1'b1;
			end else if (d_peak > 32'(cfg.valley_timeout_ms)) begin
				awaiting_n = 1'b0;
			end
		end
	end

	assign cnt_ext = 32'(cnt_n);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			awaiting_valley_q <= 1'b0;
			last_step_time_q  <= '0;
			peak_time_q       <= '0;
			last_shake_time_q <= '0;
			shake_events_q    <= '0;
			step_cnt_q        <= '0;
			out_valid_q       <= 1'b0;
		end else begin
			if (q_pop) begin
				awaiting_valley_q <= awaiting_n;
				last_step_time_q  <= last_step_n;
				peak_time_q       <= peak_n;
				last_shake_time_q <= last_shake_n;
				shake_events_q    <= events_n;
				step_cnt_q        <= cnt_n;
				out_valid_q       <= 1'b1;
			end else if (result.ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (q_pop) begin
			out_q.step_seen  <= step;
			out_q.shake_seen <= shake;
			out_q.step_total <= cnt_ext[23:0];
		end
	end

endmodule

@@ hdl/imu_step_and_shake_detector_top.sv @@
// Top level of the IMU step and shake detector.
// Takes one sample (or clear command) per cycle while sample.ready is high and returns one
// result per sample, in order. The six squares are registered at the transfer, the magnitude
// compares on those registers are written into the classification queue, and the state update
// pops the queue head into the result register and holds the queue while a result stalls.
// Up to four samples may wait ahead of the state update while a fifth result sits in the result
// register, so input keeps flowing while a finished result waits to be taken. Level registers
// take effect once their squared values are registered after the write.
module imu_step_and_shake_detector_top #(
	parameter int COUNT_BITS = 24
) (
	input  logic                                clk,
	input  logic                                arst_n,
	imu_sd_if.sink                              sample,
	imu_sd_if.source                            result,
	input  logic                                cfg_we,
	input  logic [imu_sd_pkg::REG_IDX_W-1:0]    cfg_idx,
	input  logic [imu_sd_pkg::CFG_W-1:0]        cfg_wdata
);
	import imu_sd_pkg::*;

	cfg_t   cfg_q;
	logic   q_push, q_pop, q_nempty, q_full;
	class_t q_wdata, q_head;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.step_peak_level   <= RST_STEP_PEAK;
			cfg_q.step_valley_level <= RST_STEP_VALLEY;
			cfg_q.min_step_gap_ms   <= RST_MIN_STEP_GAP;
			cfg_q.valley_timeout_ms <= RST_VALLEY_TMO;
			cfg_q.shake_accel_level <= RST_SHAKE_ACCEL;
			cfg_q.shake_gyro_level  <= RST_SHAKE_GYRO;
			cfg_q.shake_gap_ms      <= RST_SHAKE_GAP;
			cfg_q.shake_window_ms   <= RST_SHAKE_WINDOW;
		end else if (cfg_we) begin
			case (reg_idx_t'(cfg_idx))
				REG_STEP_PEAK:    cfg_q.step_peak_level   <= cfg_wdata;
				REG_STEP_VALLEY:  cfg_q.step_valley_level <= cfg_wdata;
				REG_MIN_STEP_GAP: cfg_q.min_step_gap_ms   <= cfg_wdata;
				REG_VALLEY_TMO:   cfg_q.valley_timeout_ms <= cfg_wdata;
				REG_SHAKE_ACCEL:  cfg_q.shake_accel_level <= cfg_wdata;
				REG_SHAKE_GYRO:   cfg_q.shake_gyro_level  <= cfg_wdata;
				REG_SHAKE_GAP:    cfg_q.shake_gap_ms      <= cfg_wdata;
				REG_SHAKE_WINDOW: cfg_q.shake_window_ms   <= cfg_wdata;
				default:          cfg_q <= cfg_q;
			endcase
		end
	end

	imu_sd_front u_front (
		.clk    (clk),
		.arst_n (arst_n),
		.cfg    (cfg_q),
		.sample (sample),
		.q_pop  (q_pop),
		.q_push (q_push),
		.q_data (q_wdata)
	);

	imu_sd_fifo u_fifo (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (q_push),
		.push_data (q_wdata),
		.pop       (q_pop),
		.nempty    (q_nempty),
		.full      (q_full),
		.head      (q_head)
	);

	imu_sd_back #(
		.COUNT_BITS (COUNT_BITS)
	) u_back (
		.clk      (clk),
		.arst_n   (arst_n),
		.cfg      (cfg_q),
		.q_nempty (q_nempty),
		.q_head   (q_head),
		.q_pop    (q_pop),
		.result   (result)
	);

`ifndef ASSERT_OFF
	a_pop_nonempty: assert property (@(posedge clk) disable iff (!arst_n)
		q_pop |-> q_nempty)
		else $error("queue popped while empty");

	a_push_room: assert property (@(posedge clk) disable iff (!arst_n)
		q_push |-> !q_full)
		else $error("queue pushed while full");

	a_stall_holds_queue: assert property (@(posedge clk) disable iff (!arst_n)
		(result.valid && !result.ready) |-> !q_pop)
		else $error("sample retired while result stalled");
`endif

endmodule
